### rtl/smrs_pkg.sv
// Shared types, codes and constants for the servo motion ramp/sweep unit.
// Depends on nothing; every other file in rtl imports it.
package smrs_pkg;

    localparam int FRACTION_BITS_DEF = 8;
    localparam int MUL_B_W = 17;
    localparam int DVS_W = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [11:0] ANGLE_LIMIT = 12'd500;
    localparam logic [10:0] MAP_SPAN_US = 11'd1856;
    localparam logic [23:0] MAP_SPAN_DEG = 24'd180;
    localparam logic [23:0] MS_PER_S = 24'd1000;
    localparam logic [23:0] RAMP_DIV = 24'd10000000;
    localparam logic [16:0] RAMP_T_CAP = 17'd100000;

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_ATTACH = 3'd1;
    localparam logic [2:0] OP_MOVE = 3'd2;
    localparam logic [2:0] OP_SWEEP = 3'd3;
    localparam logic [2:0] OP_STOP = 3'd4;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_STOP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 1'd1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] elapsed_ms;
        logic [11:0] target_us;
        logic [11:0] sweep_low_us;
        logic [11:0] sweep_high_us;
        logic [9:0]  sweep_increment;
    } in_item_t;

    typedef struct packed {
        logic        write_pulse;
        logic [11:0] pulse_us;
        logic [1:0]  event_code;
        logic [11:0] goal_us;
    } out_item_t;

endpackage

### rtl/smrs_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on smrs_pkg for the default multiplier width.
module smrs_mul import smrs_pkg::*; #(
    parameter int WIDTH = 52,
    parameter int B_W = MUL_B_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] op_a,
    input  logic [B_W-1:0]   op_b,
    output logic             done,
    output logic [WIDTH-1:0] product
);
    localparam int CNT_W = $clog2(B_W + 1);

    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [B_W-1:0]   b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg   <= op_a;
                b_reg   <= op_b;
                acc_reg <= '0;
                cnt_reg <= CNT_W'(B_W - 1);
                run_reg <= 1'b1;
            end else if (run_reg) begin
                if (b_reg[0]) begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg <= a_reg << 1;
                b_reg <= b_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign product = acc_reg;
endmodule

### rtl/smrs_div.sv
// Restoring divider: one quotient bit per cycle, quotient built in place.
// Depends on smrs_pkg for the default divisor width.
module smrs_div import smrs_pkg::*; #(
    parameter int WIDTH = 52,
    parameter int D_W = DVS_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [D_W-1:0]   divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [D_W:0]     shifted;
    logic             fits;
    logic [D_W:0]     diff;

    always_comb begin
        shifted = {rem_reg, quo_reg[WIDTH-1]};
        fits = shifted >= {1'b0, dvs_reg};
        diff = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg <= dividend;
                rem_reg <= '0;
                dvs_reg <= divisor;
                cnt_reg <= CNT_W'(WIDTH - 1);
                run_reg <= 1'b1;
            end else if (run_reg) begin
                // remainder stays below the divisor, so D_W bits hold it
                rem_reg <= fits ? diff[D_W-1:0] : shifted[D_W-1:0];
                quo_reg <= {quo_reg[WIDTH-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

### rtl/servo_motion_ramp_sweep_unit.sv
// Servo pulse-width ramp generator: sequencer, state and result register.
// Depends on smrs_pkg, smrs_mul and smrs_div.
//
//  Port group      Direction  Handshake            Payload
//  s_*             in         s_valid / s_ready    in_item_t request
//  m_*             out        m_valid / m_ready    out_item_t result
//  cfg_*           in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Attach, move, sweep start, stop, unused codes and ticks while idle go from idle
// straight to the output state. A moving tick at its target passes through the tick
// state, a jump or sweep step through tick and apply. A computed step runs, in order:
// three multiplies and a divide when ramping, a multiply and divide when the target is
// above 500, then one serial multiply and divide for the step itself.
// Reset is synchronous; state clears to zero, both registers to -1.
// A stalled result holds in m_item while the next request is accepted and worked on.
module servo_motion_ramp_sweep_unit import smrs_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int MATH_W = 44 + FRACTION_BITS;
    localparam int POS_W = 12 + FRACTION_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TICK, ST_TT, ST_AT, ST_VR, ST_DR, ST_MAPCHK,
        ST_MM, ST_DM, ST_STEP, ST_ME, ST_DE, ST_APPLY, ST_OUT
    } state_t;

    state_t          state_reg;
    in_item_t        item_reg;
    logic [POS_W-1:0] pos_reg;
    logic [11:0]     goal_reg;
    logic            moving_reg;
    logic            sweeping_reg;
    logic [11:0]     sw_low_reg;
    logic [11:0]     sw_high_reg;
    logic [9:0]      sw_delta_reg;
    logic [31:0]     move_time_reg;
    logic [10:0]     vel_reg;
    logic [10:0]     accel_reg;
    logic [MATH_W-1:0] vfx_reg;
    logic [MATH_W-1:0] mag_reg;
    logic            res_wr_reg;
    logic [1:0]      res_ev_reg;
    logic            m_valid_reg;
    out_item_t       m_item_reg;

    logic              mul_start_reg;
    logic [MATH_W-1:0] mul_a_reg;
    logic [MUL_B_W-1:0] mul_b_reg;
    logic              mul_done;
    logic [MATH_W-1:0] mul_prod;
    logic              div_start_reg;
    logic [MATH_W-1:0] div_n_reg;
    logic [DVS_W-1:0]  div_d_reg;
    logic              div_done;
    logic [MATH_W-1:0] div_quo;

    logic [32:0]       mt_sum;
    logic [31:0]       mt_new;
    logic [16:0]       t_cap;
    logic [11:0]       cur_int;
    logic [POS_W-1:0]  goal_fx;
    logic [MATH_W:0]   up_sum;
    logic [MATH_W-1:0] dn_diff;
    logic [POS_W-1:0]  nxt_pos;
    logic [11:0]       nxt_int;
    logic              accept;

    smrs_mul #(.WIDTH(MATH_W), .B_W(MUL_B_W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start_reg),
        .op_a(mul_a_reg), .op_b(mul_b_reg), .done(mul_done), .product(mul_prod)
    );

    smrs_div #(.WIDTH(MATH_W), .D_W(DVS_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .dividend(div_n_reg), .divisor(div_d_reg), .done(div_done), .quotient(div_quo)
    );

    always_comb begin
        accept = s_valid && (state_reg == ST_IDLE);
        mt_sum = {1'b0, move_time_reg} + 33'(s_item.elapsed_ms);
        mt_new = mt_sum[32] ? 32'hFFFF_FFFF : mt_sum[31:0];
        t_cap = (move_time_reg > 32'(RAMP_T_CAP)) ? RAMP_T_CAP : move_time_reg[16:0];
        cur_int = pos_reg[POS_W-1:FRACTION_BITS];
        goal_fx = POS_W'(goal_reg) << FRACTION_BITS;
        up_sum = {1'b0, mag_reg} + (MATH_W+1)'(pos_reg);
        dn_diff = MATH_W'(pos_reg) - mag_reg;
        if (vel_reg[10]) begin
            nxt_pos = goal_fx;
        end else if (cur_int < goal_reg) begin
            if ((up_sum >> FRACTION_BITS) > (MATH_W+1)'(goal_reg)) begin
                nxt_pos = goal_fx;
            end else begin
                nxt_pos = up_sum[POS_W-1:0];
            end
        end else if (mag_reg > MATH_W'(pos_reg)
                     || (dn_diff >> FRACTION_BITS) < MATH_W'(goal_reg)) begin
            nxt_pos = goal_fx;
        end else begin
            nxt_pos = dn_diff[POS_W-1:0];
        end
        nxt_int = nxt_pos[POS_W-1:FRACTION_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            goal_reg      <= '0;
            moving_reg    <= 1'b0;
            sweeping_reg  <= 1'b0;
            sw_low_reg    <= '0;
            sw_high_reg   <= '0;
            sw_delta_reg  <= '0;
            move_time_reg <= '0;
            vel_reg       <= '1;
            accel_reg     <= '1;
            m_valid_reg   <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            // the output state refills the slot itself
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                if (cfg_index == REG_VELOCITY) begin
                    vel_reg <= cfg_data;
                end else if (cfg_index == REG_ACCEL) begin
                    accel_reg <= cfg_data;
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        item_reg   <= s_item;
                        res_wr_reg <= 1'b0;
                        res_ev_reg <= EV_NONE;
                        state_reg  <= ST_OUT;
                        if (s_item.opcode == OP_TICK) begin
                            move_time_reg <= mt_new;
                            if (moving_reg) begin
                                state_reg <= ST_TICK;
                            end
                        end else if (s_item.opcode == OP_ATTACH) begin
                            pos_reg    <= POS_W'(s_item.target_us) << FRACTION_BITS;
                            goal_reg   <= s_item.target_us;
                            res_wr_reg <= 1'b1;
                        end else if (s_item.opcode == OP_MOVE) begin
                            goal_reg      <= s_item.target_us;
                            moving_reg    <= 1'b1;
                            move_time_reg <= '0;
                            res_ev_reg    <= EV_START;
                        end else if (s_item.opcode == OP_SWEEP) begin
                            sw_low_reg   <= s_item.sweep_low_us;
                            sw_high_reg  <= s_item.sweep_high_us;
                            sw_delta_reg <= s_item.sweep_increment;
                            goal_reg     <= s_item.sweep_high_us;
                            moving_reg   <= 1'b1;
                            sweeping_reg <= 1'b1;
                            res_ev_reg   <= EV_START;
                        end else if (s_item.opcode == OP_STOP) begin
                            moving_reg   <= 1'b0;
                            sweeping_reg <= 1'b0;
                            res_ev_reg   <= EV_STOP;
                        end
                    end
                end
                ST_TICK: begin
                    if (cur_int == goal_reg) begin
                        state_reg <= ST_OUT;
                        if (sweeping_reg) begin
                            goal_reg <= (goal_reg == sw_low_reg) ? sw_high_reg : sw_low_reg;
                        end else begin
                            moving_reg <= 1'b0;
                            res_ev_reg <= EV_STOP;
                        end
                    end else if (vel_reg[10]) begin
                        state_reg <= ST_APPLY;
                    end else if (sweeping_reg) begin
                        mag_reg   <= MATH_W'(sw_delta_reg) << FRACTION_BITS;
                        state_reg <= ST_APPLY;
                    end else if (accel_reg == '1) begin
                        vfx_reg   <= MATH_W'(vel_reg[9:0]) << FRACTION_BITS;
                        state_reg <= ST_MAPCHK;
                    end else if (accel_reg[10]) begin
                        // any other negative ramp factor stalls the velocity at zero
                        vfx_reg   <= '0;
                        state_reg <= ST_MAPCHK;
                    end else begin
                        mul_a_reg     <= MATH_W'(t_cap);
                        mul_b_reg     <= t_cap;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_TT;
                    end
                end
                ST_TT: begin
                    if (mul_done) begin
                        mul_a_reg     <= mul_prod;
                        mul_b_reg     <= MUL_B_W'(accel_reg[9:0]);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_AT;
                    end
                end
                ST_AT: begin
                    if (mul_done) begin
                        mul_a_reg <= (mul_prod > MATH_W'(RAMP_DIV)) ? MATH_W'(RAMP_DIV)
                                                                     : mul_prod;
                        mul_b_reg     <= MUL_B_W'(vel_reg[9:0]);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_VR;
                    end
                end
                ST_VR: begin
                    if (mul_done) begin
                        div_n_reg     <= mul_prod << FRACTION_BITS;
                        div_d_reg     <= RAMP_DIV;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DR;
                    end
                end
                ST_DR: begin
                    if (div_done) begin
                        vfx_reg   <= div_quo;
                        state_reg <= ST_MAPCHK;
                    end
                end
                ST_MAPCHK: begin
                    if (goal_reg > ANGLE_LIMIT) begin
                        // degrees per second to microseconds per second
                        mul_a_reg     <= MATH_W'(vfx_reg[FRACTION_BITS +: 10]);
                        mul_b_reg     <= MUL_B_W'(MAP_SPAN_US);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MM;
                    end else begin
                        state_reg <= ST_STEP;
                    end
                end
                ST_MM: begin
                    if (mul_done) begin
                        div_n_reg     <= mul_prod;
                        div_d_reg     <= MAP_SPAN_DEG;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DM;
                    end
                end
                ST_DM: begin
                    if (div_done) begin
                        vfx_reg   <= div_quo << FRACTION_BITS;
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    mul_a_reg     <= vfx_reg;
                    mul_b_reg     <= MUL_B_W'(item_reg.elapsed_ms);
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_ME;
                end
                ST_ME: begin
                    if (mul_done) begin
                        div_n_reg     <= mul_prod;
                        div_d_reg     <= MS_PER_S;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DE;
                    end
                end
                ST_DE: begin
                    if (div_done) begin
                        mag_reg   <= div_quo;
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    pos_reg   <= nxt_pos;
                    state_reg <= ST_OUT;
                    if (nxt_int != cur_int) begin
                        res_wr_reg <= 1'b1;
                        if (!sweeping_reg && nxt_int == goal_reg) begin
                            moving_reg <= 1'b0;
                            res_ev_reg <= EV_STOP;
                        end
                    end
                end
                ST_OUT: begin
                    // hold until the result slot is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg            <= 1'b1;
                        m_item_reg.write_pulse <= res_wr_reg;
                        m_item_reg.pulse_us    <= cur_int;
                        m_item_reg.event_code  <= res_ev_reg;
                        m_item_reg.goal_us     <= goal_reg;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item = m_item_reg;
    assign cfg_ready = 1'b1;
endmodule

### rtl/smrs_checker.sv
// Port-level checks for servo_motion_ramp_sweep_unit, attached by bind.
// Depends on smrs_pkg and the top level's port list.
module smrs_checker import smrs_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in work");

    // move and sweep start never drive a new pulse width
    a_start_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.event_code == EV_START |-> !m_item.write_pulse)
        else $error("motion start reported with a pulse write");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind servo_motion_ramp_sweep_unit smrs_checker u_smrs_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_item(s_item), .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
);

### bench/tb_servo_motion_ramp_sweep_unit.sv
// Self-checking bench for servo_motion_ramp_sweep_unit: bursty request driver, stalling
// result monitor and an in-bench model of the ramp/sweep arithmetic.
// Depends on smrs_pkg and the RTL of the unit.
module tb_servo_motion_ramp_sweep_unit import smrs_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRACTION_BITS_DEF;
    localparam int LATENCY_WAIT = 400;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_item;
    logic m_valid;
    logic m_ready;
    out_item_t m_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    servo_motion_ramp_sweep_unit uut (.*);

    // predictor state
    logic [63:0] pos_fx;
    logic [11:0] goal;
    logic moving, sweeping;
    logic [11:0] sw_lo, sw_hi;
    logic [9:0] sw_step;
    logic [31:0] run_ms;
    logic signed [10:0] vel_lim, acc_rate;

    in_item_t pending_q[$];
    out_item_t expected_q[$];
    int errors = 0;
    int checked = 0;
    int gap_left = 0;
    int burst_left = 0;
    logic drive_en = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report(string what, logic [11:0] got, logic [11:0] want);
        errors++;
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, checked);
    endtask

    function automatic logic [63:0] pulse_step(logic [63:0] el);
        logic [63:0] vel, vfx, t, r;
        vel = 64'(signed'(vel_lim));
        if (acc_rate == -11'sd1) vfx = vel << FB;
        else if (acc_rate < 0) vfx = 0;
        else begin
            t = run_ms;
            if (t > 100000) t = 100000;
            r = 64'(acc_rate) * t * t;
            if (r > 10000000) r = 10000000;
            vfx = ((vel * r) << FB) / 10000000;
        end
        if (goal > 12'd500) vfx = (((vfx >> FB) * 1856) / 180) << FB;
        return vfx * el / 1000;
    endfunction

    function automatic out_item_t predict_pulse(in_item_t it);
        out_item_t o;
        logic wr;
        logic [1:0] ev;
        logic [63:0] cur_i, gfx, nxt, mag, sum;
        wr = 0;
        ev = EV_NONE;
        case (it.opcode)
            OP_TICK: begin
                sum = 64'(run_ms) + 64'(it.elapsed_ms);
                run_ms = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                if (moving) begin
                    cur_i = pos_fx >> FB;
                    gfx = 64'(goal) << FB;
                    if (cur_i != 64'(goal)) begin
                        if (vel_lim < 0) nxt = gfx;
                        else begin
                            mag = sweeping ? (64'(sw_step) << FB)
                                           : pulse_step(64'(it.elapsed_ms));
                            if (cur_i < 64'(goal)) begin
                                nxt = pos_fx + mag;
                                if ((nxt >> FB) > 64'(goal)) nxt = gfx;
                            end else if (mag > pos_fx || ((pos_fx - mag) >> FB) < 64'(goal))
                                nxt = gfx;
                            else nxt = pos_fx - mag;
                        end
                        pos_fx = nxt;
                        if ((nxt >> FB) != cur_i) begin
                            wr = 1;
                            if (!sweeping && (nxt >> FB) == 64'(goal)) begin
                                moving = 0;
                                ev = EV_STOP;
                            end
                        end
                    end else if (sweeping) goal = (goal == sw_lo) ? sw_hi : sw_lo;
                    else begin
                        moving = 0;
                        ev = EV_STOP;
                    end
                end
            end
            OP_ATTACH: begin
                pos_fx = 64'(it.target_us) << FB;
                goal = it.target_us;
                wr = 1;
            end
            OP_MOVE: begin
                goal = it.target_us;
                moving = 1;
                run_ms = 0;
                ev = EV_START;
            end
            OP_SWEEP: begin
                sw_lo = it.sweep_low_us;
                sw_hi = it.sweep_high_us;
                sw_step = it.sweep_increment;
                goal = sw_hi;
                moving = 1;
                sweeping = 1;
                ev = EV_START;
            end
            OP_STOP: begin
                moving = 0;
                sweeping = 0;
                ev = EV_STOP;
            end
            default: ;
        endcase
        o.write_pulse = wr;
        o.pulse_us = pos_fx[FB+11:FB];
        o.event_code = ev;
        o.goal_us = goal;
        return o;
    endfunction

    // driver: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else if (s_valid && !s_ready) begin
            // hold request
        end else if (gap_left > 0) begin
            s_valid <= 0;
            gap_left <= gap_left - 1;
        end else if (drive_en && pending_q.size() > 0) begin
            s_item <= pending_q[0];
            expected_q.push_back(predict_pulse(pending_q[0]));
            void'(pending_q.pop_front());
            s_valid <= 1;
            if (burst_left == 0) begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else burst_left <= burst_left - 1;
        end else begin
            s_valid <= 0;
        end
    end

    // monitor: stall pattern of its own
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= ($urandom_range(0, 9) < (checked[6] ? 9 : 5));
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                errors++;
                $display("unexpected result %0d", checked);
            end else begin
                if (m_item.write_pulse !== expected_q[0].write_pulse)
                    report("write_pulse", 12'(m_item.write_pulse),
                           12'(expected_q[0].write_pulse));
                if (m_item.pulse_us !== expected_q[0].pulse_us)
                    report("pulse_us", m_item.pulse_us, expected_q[0].pulse_us);
                if (m_item.event_code !== expected_q[0].event_code)
                    report("event_code", 12'(m_item.event_code),
                           12'(expected_q[0].event_code));
                if (m_item.goal_us !== expected_q[0].goal_us)
                    report("goal_us", m_item.goal_us, expected_q[0].goal_us);
                void'(expected_q.pop_front());
            end
            checked++;
        end
    end

    function automatic in_item_t make_req(logic [2:0] op, logic [15:0] el, logic [11:0] tg,
                                          logic [11:0] lo, logic [11:0] hi, logic [9:0] inc);
        in_item_t it;
        it.opcode = op;
        it.elapsed_ms = el;
        it.target_us = tg;
        it.sweep_low_us = lo;
        it.sweep_high_us = hi;
        it.sweep_increment = inc;
        return it;
    endfunction

    function automatic in_item_t rand_req();
        in_item_t it;
        int k;
        it = make_req(OP_TICK, 16'($urandom_range(0, 40)), 12'($urandom), 12'($urandom),
                      12'($urandom), 10'($urandom));
        k = $urandom_range(0, 99);
        if (k < 62) begin
            it.opcode = OP_TICK;
            if ($urandom_range(0, 19) == 0) it.elapsed_ms = 16'($urandom);
        end else if (k < 72) begin
            it.opcode = OP_MOVE;
            if ($urandom_range(0, 1)) it.target_us = 12'($urandom_range(0, 500));
            else it.target_us = 12'($urandom_range(500, 2600));
        end else if (k < 78) it.opcode = OP_ATTACH;
        else if (k < 86) begin
            it.opcode = OP_SWEEP;
            it.sweep_low_us = 12'($urandom_range(400, 1500));
            it.sweep_high_us = it.sweep_low_us + 12'($urandom_range(0, 1500));
            it.sweep_increment = ($urandom_range(0, 5) == 0) ? 10'($urandom)
                                                              : 10'($urandom_range(0, 80));
        end else if (k < 92) it.opcode = OP_STOP;
        else if (k < 96) it.opcode = 3'($urandom_range(5, 7));
        else it = make_req(3'($urandom_range(0, 4)), 16'($urandom), 12'($urandom),
                           12'($urandom), 12'($urandom), 10'($urandom));
        return it;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic signed [10:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        if (idx == REG_VELOCITY) vel_lim = val;
        else acc_rate = val;
    endtask

    task automatic run_phase(int n_items, int max_wait);
        int waited;
        for (int i = 0; i < n_items; i++) pending_q.push_back(rand_req());
        drive_en = 1;
        waited = 0;
        while ((pending_q.size() > 0 || expected_q.size() > 0 || s_valid) && waited < max_wait) begin
            @(posedge aclk);
            waited++;
        end
        drive_en = 0;
        if (waited >= max_wait) begin
            $display("simulation failed");
            $finish;
        end
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    initial begin
        logic signed [10:0] vel_set[6];
        logic signed [10:0] acc_set[6];
        vel_set = '{-11'sd1, 11'sd1023, 11'sd0, 11'sd90, 11'sd400, -11'sd1024};
        acc_set = '{-11'sd1, 11'sd1023, 11'sd0, -11'sd5, 11'sd3, -11'sd1};
        aresetn = 0;
        s_valid = 0;
        s_item = '0;
        cfg_valid = 0;
        cfg_index = REG_VELOCITY;
        cfg_data = '0;
        pos_fx = 0; goal = 0; moving = 0; sweeping = 0;
        sw_lo = 0; sw_hi = 0; sw_step = 0; run_ms = 0;
        vel_lim = -11'sd1; acc_rate = -11'sd1;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset settings (jump), all defined opcodes, unused codes 5 and 7 and field extremes
        pending_q.push_back(make_req(OP_TICK, 16'hFFFF, 0, 0, 0, 0));
        pending_q.push_back(make_req(OP_ATTACH, 0, 12'hFFF, 0, 0, 0));
        pending_q.push_back(make_req(OP_MOVE, 0, 12'd0, 0, 0, 0));
        pending_q.push_back(make_req(OP_TICK, 16'd10, 0, 0, 0, 0));
        pending_q.push_back(make_req(OP_TICK, 16'd1, 0, 0, 0, 0));
        pending_q.push_back(make_req(3'd5, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 10'h3FF));
        pending_q.push_back(make_req(3'd7, 0, 0, 0, 0, 0));
        pending_q.push_back(make_req(OP_SWEEP, 0, 0, 12'd0, 12'hFFF, 10'h3FF));
        pending_q.push_back(make_req(OP_TICK, 16'd1, 0, 0, 0, 0));
        pending_q.push_back(make_req(OP_TICK, 16'd1, 0, 0, 0, 0));
        pending_q.push_back(make_req(OP_MOVE, 0, 12'd600, 0, 0, 0));
        pending_q.push_back(make_req(OP_TICK, 16'd1, 0, 0, 0, 0));
        pending_q.push_back(make_req(OP_TICK, 16'd1, 0, 0, 0, 0));
        pending_q.push_back(make_req(OP_STOP, 0, 0, 0, 0, 0));
        pending_q.push_back(make_req(OP_TICK, 16'd5, 0, 0, 0, 0));
        pending_q.push_back(make_req(OP_SWEEP, 0, 0, 12'd1000, 12'd1000, 10'd0));
        pending_q.push_back(make_req(OP_TICK, 16'd5, 0, 0, 0, 0));
        pending_q.push_back(make_req(OP_STOP, 0, 0, 0, 0, 0));
        drive_en = 1;
        while (pending_q.size() > 0 || expected_q.size() > 0 || s_valid) @(posedge aclk);
        drive_en = 0;
        repeat (LATENCY_WAIT) @(posedge aclk);

        // random phases across register settings, extremes included
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_VELOCITY, vel_set[p]);
            write_reg(REG_ACCEL, acc_set[p]);
            run_phase(65, 2_000_000);
        end

        $display("checked %0d results over 6 velocity/ramp settings plus directed cases",
                 checked);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

### servo_motion_ramp_sweep_unit.f
rtl/smrs_pkg.sv
rtl/smrs_mul.sv
rtl/smrs_div.sv
rtl/servo_motion_ramp_sweep_unit.sv
rtl/smrs_checker.sv
bench/tb_servo_motion_ramp_sweep_unit.sv
